// ===== rtl/utf8_cyrillic_glyph_recoder_assert.svh =====
// Assertion macros for the UTF-8 glyph recoder.
`ifndef UTF8_CYRILLIC_GLYPH_RECODER_ASSERT_SVH
`define UTF8_CYRILLIC_GLYPH_RECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UCGR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ucgr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UCGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ucgr assertion failed");

`endif

// ===== rtl/ucgr_pkg.sv =====
// Shared types and constants for the UTF-8 glyph recoder.
`timescale 1ns / 1ps

package ucgr_pkg;

    localparam int BYTE_W = 8;

    typedef logic [BYTE_W-1:0] t_byte;

    // UTF-8 lead bytes that are remembered
    localparam t_byte LEAD_BYTE_D0 = 8'hD0;
    localparam t_byte LEAD_BYTE_D1 = 8'hD1;
    localparam t_byte LEAD_BYTE_D2 = 8'hD2;
    localparam t_byte LEAD_BYTE_C2 = 8'hC2;

    localparam t_byte GLYPH_STAR = 8'd42;
    localparam t_byte ASCII_LO   = 8'd32;
    localparam t_byte ASCII_HI   = 8'd126;
    localparam t_byte GLYPH_MAX  = 8'd208;

    localparam t_byte D0_SHIFT = 8'd17;
    localparam t_byte D1_SHIFT = 8'd47;

    // Pending lead byte, one-hot
    typedef enum logic [4:0] {
        LEAD_NONE = 5'b00001,
        LEAD_D0   = 5'b00010,
        LEAD_D1   = 5'b00100,
        LEAD_D2   = 5'b01000,
        LEAD_C2   = 5'b10000
    } t_lead;

    // Input register contents
    typedef struct packed {
        logic  valid;
        t_byte data;
    } t_s1;

    // Decoder result and status
    typedef struct packed {
        logic  is_lead;
        logic  lead_none;
        t_byte glyph;
    } t_dec;

endpackage

// ===== rtl/ucgr_if.sv =====
// Stream interfaces for raw bytes in and glyph codes out.
`timescale 1ns / 1ps

interface ucgr_byte_if;
    logic                 valid;
    logic                 ready;
    ucgr_pkg::t_byte      in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface ucgr_glyph_if;
    logic                 valid;
    logic                 ready;
    ucgr_pkg::t_byte      glyph_code;

    modport source (output valid, output glyph_code, input ready);
    modport sink   (input valid, input glyph_code, output ready);
endinterface

// ===== rtl/ucgr_in_stage.sv =====
// Input register stage: captures one byte per accepted transaction.
`timescale 1ns / 1ps

module ucgr_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ucgr_byte_if.sink          i_in,
    input  logic               i_advance,
    output ucgr_pkg::t_s1      o_s1
);

    logic            r_valid;
    logic            n_valid;
    ucgr_pkg::t_byte r_data;
    logic            accept;

    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_in.in_byte;
        end
    end

    assign o_s1.valid = r_valid;
    assign o_s1.data  = r_data;

endmodule

// ===== rtl/ucgr_decoder.sv =====
// Lead byte tracking and glyph mapping for the registered input byte.
`timescale 1ns / 1ps

module ucgr_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ucgr_pkg::t_s1      i_s1,
    input  logic               i_advance,
    output ucgr_pkg::t_dec     o_dec
);

    ucgr_pkg::t_lead r_lead;
    ucgr_pkg::t_lead n_lead;
    ucgr_pkg::t_byte b;
    ucgr_pkg::t_byte glyph;
    logic            is_lead;

    assign b = i_s1.data;

    always_comb begin
        is_lead = 1'b1;
        n_lead  = r_lead;
        glyph   = ucgr_pkg::GLYPH_STAR;
        case (b)
            ucgr_pkg::LEAD_BYTE_D0: n_lead = ucgr_pkg::LEAD_D0;
            ucgr_pkg::LEAD_BYTE_D1: n_lead = ucgr_pkg::LEAD_D1;
            ucgr_pkg::LEAD_BYTE_D2: n_lead = ucgr_pkg::LEAD_D2;
            ucgr_pkg::LEAD_BYTE_C2: n_lead = ucgr_pkg::LEAD_C2;
            default: begin
                is_lead = 1'b0;
                n_lead  = ucgr_pkg::LEAD_NONE;
                case (r_lead)
                    ucgr_pkg::LEAD_NONE: begin
                        if (b >= ucgr_pkg::ASCII_LO && b <= ucgr_pkg::ASCII_HI) begin
                            glyph = b;
                        end
                    end
                    ucgr_pkg::LEAD_D0: begin
                        if (b >= 8'd144 && b <= 8'd191) begin
                            glyph = b - ucgr_pkg::D0_SHIFT;
                        end else begin
                            case (b)
                                8'd129:  glyph = 8'd191;
                                8'd131:  glyph = 8'd193;
                                8'd132:  glyph = 8'd195;
                                8'd134:  glyph = 8'd197;
                                8'd135:  glyph = 8'd199;
                                8'd142:  glyph = 8'd201;
                                default: glyph = ucgr_pkg::GLYPH_STAR;
                            endcase
                        end
                    end
                    ucgr_pkg::LEAD_D1: begin
                        if (b >= 8'd128 && b <= 8'd143) begin
                            glyph = b + ucgr_pkg::D1_SHIFT;
                        end else begin
                            case (b)
                                8'd145:  glyph = 8'd192;
                                8'd147:  glyph = 8'd194;
                                8'd148:  glyph = 8'd196;
                                8'd150:  glyph = 8'd198;
                                8'd151:  glyph = 8'd200;
                                8'd158:  glyph = 8'd202;
                                default: glyph = ucgr_pkg::GLYPH_STAR;
                            endcase
                        end
                    end
                    ucgr_pkg::LEAD_D2: begin
                        case (b)
                            8'd144:  glyph = 8'd203;
                            8'd145:  glyph = 8'd204;
                            default: glyph = ucgr_pkg::GLYPH_STAR;
                        endcase
                    end
                    ucgr_pkg::LEAD_C2: begin
                        case (b)
                            8'd167:  glyph = 8'd205;
                            8'd176:  glyph = 8'd206;
                            8'd177:  glyph = 8'd207;
                            8'd181:  glyph = 8'd208;
                            default: glyph = ucgr_pkg::GLYPH_STAR;
                        endcase
                    end
                    default: glyph = ucgr_pkg::GLYPH_STAR;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= ucgr_pkg::LEAD_NONE;
        end else if (i_advance) begin
            r_lead <= n_lead;
        end
    end

    assign o_dec.is_lead   = is_lead;
    assign o_dec.lead_none = (r_lead == ucgr_pkg::LEAD_NONE);
    assign o_dec.glyph     = glyph;

endmodule

// ===== rtl/utf8_cyrillic_glyph_recoder.sv =====
// UTF-8 to glyph code recoder: input register, decode, result register.
// A byte accepted into the input register has its glyph code loaded into the result
//   register when the decode stage advances, and is offered from there.
// Throughput: one byte per cycle while the result register is empty or being read,
//   set by the single decode stage between the registers; lead bytes give no result.
// Reset (synchronous, active low) empties both registers and clears the pending lead.
`timescale 1ns / 1ps

`include "utf8_cyrillic_glyph_recoder_assert.svh"

module utf8_cyrillic_glyph_recoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ucgr_byte_if.sink      i_in,
    ucgr_glyph_if.source   o_out
);

    ucgr_pkg::t_s1   s1;
    ucgr_pkg::t_dec  dec;
    logic            s1_adv;
    logic            load_out;
    logic            r_out_valid;
    logic            n_out_valid;
    ucgr_pkg::t_byte r_out_glyph;

    // lead bytes drain without needing room in the result register
    assign s1_adv   = s1.valid && (dec.is_lead || !r_out_valid || o_out.ready);
    assign load_out = s1_adv && !dec.is_lead;

    ucgr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (s1_adv),
        .o_s1      (s1)
    );

    ucgr_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (s1),
        .i_advance (s1_adv),
        .o_dec     (dec)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_glyph <= dec.glyph;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.glyph_code = r_out_glyph;

    `UCGR_ASSERT_NOW(a_glyph_range, i_clk, i_rst_n, r_out_valid,
        r_out_glyph >= ucgr_pkg::ASCII_LO && r_out_glyph <= ucgr_pkg::GLYPH_MAX)
    `UCGR_ASSERT_NEXT(a_lead_cleared, i_clk, i_rst_n, load_out, dec.lead_none)
    `UCGR_ASSERT_NEXT(a_lead_no_result, i_clk, i_rst_n,
        s1_adv && dec.is_lead && r_out_valid && !o_out.ready, $stable(r_out_glyph))
    `UCGR_ASSERT_NOW(a_out_rise_src, i_clk, i_rst_n, $rose(r_out_valid), $past(load_out))

endmodule
